### hw/rtl/fwr_pkg.sv
package fwr_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIN,
    S_FRONT
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] popped_value;
    logic [31:0] front_value;
    logic [4:0]  entry_count;
  } rsp_t;

endpackage

### hw/rtl/fwr_mem.sv
module fwr_mem #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fifo_with_remove_by_value_top.sv
// Channel   Ports                      Direction  Transaction
// request   start, busy, req_i         in         start high while busy low
// result    rsp_valid_o, rsp_o         out        rsp_valid_o high for one cycle
//
// Push and clear keep busy low: the result appears in the next cycle.
// Pop on a non-empty queue makes one memory read to fetch the new head.
// Remove reads and compares each entry from the head (address, then registered data); on a match
// it shifts each later entry one place toward the head, then rereads the head if entries remain.
// Reset empties the queue at once; the entry memory is not cleared.
// The receiver cannot stall results.
module fifo_with_remove_by_value_top
  import fwr_pkg::*;
#(
  parameter int unsigned ELEMENT_BITS = 32,
  parameter int unsigned QUEUE_DEPTH  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Ring index: base plus offset, wrapped at the queue depth.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [AW+1:0] sum;
    sum = (AW+2)'(base) + (AW+2)'(off);
    if (sum >= (AW+2)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+2)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e                  state_q, state_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [ELEMENT_BITS-1:0] front_q, front_d;
  logic [ELEMENT_BITS-1:0] val_q, val_d;
  status_e                 status_q, status_d;
  logic [31:0]             popped_q, popped_d;
  logic                    rsp_valid_q, rsp_valid_d;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [ELEMENT_BITS-1:0] mem_wdata, mem_rdata;
  logic [ELEMENT_BITS-1:0] req_val;
  logic [CW-1:0]           idx_ext, idx_nxt, cnt_last;

  assign req_val  = ELEMENT_BITS'(req_i.value);
  assign idx_ext  = CW'(idx_q);
  assign idx_nxt  = idx_ext + CW'(1);
  assign cnt_last = cnt_q - CW'(1);

  fwr_mem #(
    .WIDTH(ELEMENT_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    front_q  <= front_d;
    val_q    <= val_d;
    status_q <= status_d;
    popped_q <= popped_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    front_d     = front_q;
    val_d       = val_q;
    status_d    = status_q;
    popped_d    = popped_q;
    rsp_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wrap_add(head_q, idx_ext);
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d    = req_val;
          popped_d = '0;
          status_d = ST_DONE;
          unique case (req_i.op)
            OP_PUSH: begin
              rsp_valid_d = 1'b1;
              if (cnt_q == CW'(QUEUE_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_add(head_q, cnt_q);
                mem_wdata = req_val;
                if (cnt_q == '0) begin
                  front_d = req_val;
                end
                cnt_d = cnt_q + CW'(1);
              end
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                status_d    = ST_EMPTY;
                rsp_valid_d = 1'b1;
              end else begin
                popped_d  = 32'(front_q);
                head_d    = wrap_add(head_q, CW'(1));
                cnt_d     = cnt_last;
                mem_re    = 1'b1;
                mem_raddr = wrap_add(head_q, CW'(1));
                state_d   = S_FRONT;
              end
            end
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                status_d    = ST_NOMATCH;
                rsp_valid_d = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_SRCH_RD;
              end
            end
            OP_CLEAR: begin
              cnt_d       = '0;
              rsp_valid_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SRCH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = wrap_add(head_q, idx_ext);
        state_d   = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (mem_rdata == val_q) begin
          if (idx_ext == cnt_last) begin
            cnt_d   = cnt_last;
            state_d = S_FIN;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else if (idx_ext == cnt_last) begin
          status_d    = ST_NOMATCH;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = wrap_add(head_q, idx_nxt);
        state_d   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        // Move the entry behind the gap one place toward the head.
        mem_we    = 1'b1;
        mem_waddr = wrap_add(head_q, idx_ext);
        mem_wdata = mem_rdata;
        if (idx_nxt == cnt_last) begin
          cnt_d   = cnt_last;
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SHIFT_RD;
        end
      end
      S_FIN: begin
        if (cnt_q == '0) begin
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_q;
          state_d   = S_FRONT;
        end
      end
      S_FRONT: begin
        front_d     = mem_rdata;
        status_d    = ST_DONE;
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    rsp_o.status       = status_q;
    rsp_o.popped_value = popped_q;
    rsp_o.front_value  = (cnt_q != '0) ? 32'(front_q) : 32'd0;
    rsp_o.entry_count  = 5'(cnt_q);
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_push_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.op == OP_PUSH || req_i.op == OP_CLEAR)) |=> rsp_valid_o)
    else $error("push or clear did not finish in one cycle");

  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_EMPTY) |-> (cnt_q == '0))
    else $error("empty status reported with entries held");

  a_mem_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

endmodule
